// ===== rtl/core/sals_pkg.sv =====
// Shared types, constants and codes for the set-associative LRU cache model.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package sals_pkg;

    localparam int MAX_SETS     = 64;
    localparam int MAX_WAYS     = 4;
    localparam int ADDR_WIDTH   = 64;

    localparam int SET_W        = $clog2(MAX_SETS);
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W       = WAY_W;
    localparam int TAG_W        = ADDR_WIDTH;
    localparam int CNT_W        = 32;

    // Configuration register widths
    localparam int SB_W         = 3;
    localparam int WAYS_W       = 3;
    localparam int BB_W         = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    localparam logic [SB_W-1:0]   MAX_SET_BITS = SB_W'(SET_W);
    localparam logic [WAYS_W-1:0] WAYS_MAX     = WAYS_W'(MAX_WAYS);
    localparam logic [WAYS_W-1:0] WAYS_MIN     = WAYS_W'(1);

    // Stream payload widths
    localparam int ACT_W        = 2;
    localparam int IN_TDATA_W   = ((ADDR_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + 3 * CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_row_t;
    typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Row write toward the line store
    typedef struct packed {
        logic             en;
        logic             fill;
        logic [SET_W-1:0] set;
        logic [WAY_W-1:0] way;
        logic [TAG_W-1:0] tag;
        rank_row_t        ranks;
    } store_wr_t;

    // Outcome of the way scan
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             empty_found;
        logic [WAY_W-1:0] empty_way;
        logic [WAY_W-1:0] lru_way;
    } scan_res_t;

    function automatic rank_row_t rank_init();
        rank_row_t r;
        for (int i = 0; i < MAX_WAYS; i++) begin
            r[i] = RANK_W'(i);
        end
        return r;
    endfunction

    localparam rank_row_t RANK_RESET = rank_init();

endpackage

`default_nettype wire

// ===== rtl/core/sals_store.sv =====
// Line store: tag and recency-rank memories, one row per set, plus valid flags.
// Depends on sals_pkg.
`default_nettype none

module sals_store
    import sals_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire logic [SET_W-1:0]   rd_set,
    input  wire store_wr_t          wr,
    output tag_row_t                rd_tags,
    output rank_row_t               rd_ranks,
    output logic [MAX_WAYS-1:0]     rd_valid
);

    tag_row_t             tag_mem [MAX_SETS];
    rank_row_t            rank_mem [MAX_SETS];
    tag_row_t             tag_rd_reg;
    rank_row_t            rank_rd_reg;
    logic [MAX_WAYS-1:0]  valid_reg [MAX_SETS];
    logic                 touched_reg [MAX_SETS];
    logic [MAX_WAYS-1:0]  valid_rd_reg;
    logic                 touched_rd_reg;
    tag_row_t             tag_merge;

    // Replace the filled way within the row read for this access
    always_comb
    begin
        tag_merge = tag_rd_reg;
        if (wr.fill)
        begin
            tag_merge[wr.way] = wr.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tag_mem[wr.set]  <= tag_merge;
            rank_mem[wr.set] <= wr.ranks;
        end
        if (rd_en)
        begin
            tag_rd_reg  <= tag_mem[rd_set];
            rank_rd_reg <= rank_mem[rd_set];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SETS; s++)
            begin
                valid_reg[s]   <= '0;
                touched_reg[s] <= 1'b0;
            end
            valid_rd_reg   <= '0;
            touched_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                touched_reg[wr.set] <= 1'b1;
                if (wr.fill)
                begin
                    valid_reg[wr.set][wr.way] <= 1'b1;
                end
            end
            if (rd_en)
            begin
                valid_rd_reg   <= valid_reg[rd_set];
                touched_rd_reg <= touched_reg[rd_set];
            end
        end
    end

    assign rd_tags  = tag_rd_reg;
    assign rd_ranks = touched_rd_reg ? rank_rd_reg : RANK_RESET;
    assign rd_valid = valid_rd_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sals_scan.sv =====
// Way scan: one tag compare per step cycle, tracking hit, first empty and LRU way.
// Depends on sals_pkg.
`default_nettype none

module sals_scan
    import sals_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clear,
    input  wire logic               step,
    input  wire logic [WAY_W-1:0]   way,
    input  wire logic               line_valid,
    input  wire logic [TAG_W-1:0]   line_tag,
    input  wire logic [RANK_W-1:0]  line_rank,
    input  wire logic [TAG_W-1:0]   key_tag,
    output scan_res_t               res
);

    scan_res_t           res_reg;
    scan_res_t           res_next;
    logic [RANK_W-1:0]   best_reg;
    logic [RANK_W-1:0]   best_next;

    always_comb
    begin
        res_next  = res_reg;
        best_next = best_reg;
        if (clear)
        begin
            res_next  = '0;
            best_next = '0;
        end
        else if (step)
        begin
            // Later matching way wins
            if (line_valid && (line_tag == key_tag))
            begin
                res_next.hit     = 1'b1;
                res_next.hit_way = way;
            end
            if (!line_valid && !res_reg.empty_found)
            begin
                res_next.empty_found = 1'b1;
                res_next.empty_way   = way;
            end
            if (line_rank >= best_reg)
            begin
                best_next        = line_rank;
                res_next.lru_way = way;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg  <= '0;
            best_reg <= '0;
        end
        else
        begin
            res_reg  <= res_next;
            best_reg <= best_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_lru_cache_sim.sv =====
// Set-associative LRU cache tag model: sequencer, counters and stream ports.
// Result shows on m_tvalid after READ, SCAN, UPDATE and DONE (ways in use 1..4).
// One access at a time (s_tready only in IDLE); the scan compares one tag per cycle.
// A pending result in the output register does not stall the next access until done.
// Reset (rst_n low, asynchronous): cache empty, ranks by way index, counters zero,
// registers set_bits 0, ways 1, block_bits 0. No clearing pass; ready right after reset.
`default_nettype none

module set_assoc_lru_cache_sim
    import sals_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Access stream in
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [63:0] address
    input  wire logic [ACT_W-1:0]       s_tuser,   // [1:0] action
    // Result stream out
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [0] hit, [1] evicted,
                                                   // [33:2] hits_total,
                                                   // [65:34] misses_total,
                                                   // [97:66] evictions_total, rest 0
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(n);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Configuration
    logic [SB_W-1:0]    set_bits_reg;
    logic [WAYS_W-1:0]  ways_reg;
    logic [BB_W-1:0]    block_bits_reg;
    logic [SB_W-1:0]    sb_eff;
    logic [WAYS_W-1:0]  nw_eff;

    // Sequencer and access context
    state_t             state_reg;
    state_t             state_next;
    logic [ACT_W-1:0]   act_reg;
    logic [TAG_W-1:0]   shifted_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [SET_W-1:0]   set_reg;
    logic [WAY_W-1:0]   way_cnt_reg;
    logic [TAG_W-1:0]   tag_now;
    logic [SET_W-1:0]   set_idx_mask;
    logic [SET_W-1:0]   set_now;

    logic               accept;
    logic               rd_en;
    logic               scan_clear;
    logic               scan_step;
    logic               scan_last;
    logic               do_update;
    logic               out_load;

    // Store and scan
    tag_row_t            rd_tags;
    rank_row_t           rd_ranks;
    logic [MAX_WAYS-1:0] rd_valid;
    scan_res_t           scan;
    store_wr_t           wr;

    // Update
    logic [WAY_W-1:0]   victim;
    logic [WAY_W-1:0]   target;
    logic [RANK_W-1:0]  old_rank;
    rank_row_t          new_ranks;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [CNT_W-1:0]   miss_cnt_reg;
    logic [CNT_W-1:0]   evict_cnt_reg;
    logic               res_hit_reg;
    logic               res_evict_reg;

    // Output register
    logic               m_tvalid_reg;
    logic               out_hit_reg;
    logic               out_evict_reg;
    logic [CNT_W-1:0]   out_hits_reg;
    logic [CNT_W-1:0]   out_misses_reg;
    logic [CNT_W-1:0]   out_evicts_reg;

    // ---------------------------------------------------------------
    // Configuration port: always ready; user must write it only while idle (block does not enforce it)
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            ways_reg       <= WAYS_MIN;
            block_bits_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[SB_W-1:0];
                CFG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BB_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp set bits to the set count and ways to 1..MAX_WAYS
    assign sb_eff = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;

    always_comb
    begin
        priority if (ways_reg == '0)
            nw_eff = WAYS_MIN;
        else if (ways_reg > WAYS_MAX)
            nw_eff = WAYS_MAX;
        else
            nw_eff = ways_reg;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign scan_last = ((WAYS_W'(way_cnt_reg) + WAYS_W'(1)) == nw_eff);

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        scan_clear = 1'b0;
        scan_step  = 1'b0;
        do_update  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Issue the set row read and reset the scan
                rd_en      = 1'b1;
                scan_clear = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                do_update  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            way_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_clear)
            begin
                way_cnt_reg <= '0;
            end
            else if (scan_step)
            begin
                way_cnt_reg <= way_cnt_reg + WAY_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Address split: offset shift at accept, set/tag split in READ
    // ---------------------------------------------------------------
    assign tag_now      = shifted_reg >> sb_eff;
    assign set_idx_mask = ~({SET_W{1'b1}} << sb_eff);
    assign set_now      = shifted_reg[SET_W-1:0] & set_idx_mask;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= s_tuser;
            shifted_reg <= s_tdata[ADDR_WIDTH-1:0] >> block_bits_reg;
        end
        if (rd_en)
        begin
            tag_reg <= tag_now;
            set_reg <= set_now;
        end
    end

    // ---------------------------------------------------------------
    // Line store and the shared way compare
    // ---------------------------------------------------------------
    sals_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_set   (set_now),
        .wr       (wr),
        .rd_tags  (rd_tags),
        .rd_ranks (rd_ranks),
        .rd_valid (rd_valid)
    );

    sals_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (scan_clear),
        .step       (scan_step),
        .way        (way_cnt_reg),
        .line_valid (rd_valid[way_cnt_reg]),
        .line_tag   (rd_tags[way_cnt_reg]),
        .line_rank  (rd_ranks[way_cnt_reg]),
        .key_tag    (tag_reg),
        .res        (scan)
    );

    // ---------------------------------------------------------------
    // Update: pick the way, promote it to most recent, write back
    // ---------------------------------------------------------------
    assign victim   = scan.empty_found ? scan.empty_way : scan.lru_way;
    assign target   = scan.hit ? scan.hit_way : victim;
    assign old_rank = rd_ranks[target];

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (rd_ranks[i] < old_rank)
                new_ranks[i] = rd_ranks[i] + RANK_W'(1);
            else
                new_ranks[i] = rd_ranks[i];
        end
        new_ranks[target] = '0;
    end

    always_comb
    begin
        wr.en    = do_update;
        wr.fill  = !scan.hit;
        wr.set   = set_reg;
        wr.way   = target;
        wr.tag   = tag_reg;
        wr.ranks = new_ranks;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            res_hit_reg   <= 1'b0;
            res_evict_reg <= 1'b0;
        end
        else if (do_update)
        begin
            res_hit_reg   <= scan.hit;
            res_evict_reg <= !scan.hit && !scan.empty_found;
            if (scan.hit)
            begin
                // A modify counts its load and its store
                hit_cnt_reg <= sat_add(hit_cnt_reg, (act_reg == ACT_MODIFY) ? 2'd2 : 2'd1);
            end
            else
            begin
                miss_cnt_reg <= sat_add(miss_cnt_reg, 2'd1);
                if (act_reg == ACT_MODIFY)
                begin
                    hit_cnt_reg <= sat_add(hit_cnt_reg, 2'd1);
                end
                if (!scan.empty_found)
                begin
                    evict_cnt_reg <= sat_add(evict_cnt_reg, 2'd1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg    <= res_hit_reg;
            out_evict_reg  <= res_evict_reg;
            out_hits_reg   <= hit_cnt_reg;
            out_misses_reg <= miss_cnt_reg;
            out_evicts_reg <= evict_cnt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_evicts_reg, out_misses_reg, out_hits_reg,
                       out_evict_reg, out_hit_reg};

endmodule

`default_nettype wire
